// ===== rtl/dle_stx_frame_receiver_defines.svh =====
// ---------------------------------------------------------------------------
// dle_stx_frame_receiver assertion macros
// Concurrent check wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DLE_STX_FRAME_RECEIVER_DEFINES_SVH
`define DLE_STX_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DSFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsfr check failed");
// next-cycle implication
`define DSFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsfr check failed");
`else
`define DSFR_ASSERT_NOW(lbl, ante, cons)
`define DSFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/dsfr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_pkg
// Shared codes, constants and result type of the DLE/STX frame receiver.
// ---------------------------------------------------------------------------
package dsfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam logic [7:0]  CH_DLE    = 8'h10;
  localparam logic [7:0]  CH_STX    = 8'h02;
  localparam logic [7:0]  CH_ETX    = 8'h03;
  localparam logic [7:0]  ODD_MASK  = 8'h4A;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam int OUT_TDATA_W = 48;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] STAGE_IDLE    = 3'd0;
  localparam logic [2:0] STAGE_STX     = 3'd1;
  localparam logic [2:0] STAGE_PAYLOAD = 3'd2;
  localparam logic [2:0] STAGE_ESCAPE  = 3'd3;
  localparam logic [2:0] STAGE_CHECK   = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_STX     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_ESCAPE  = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    RP_IDLE = 3'b001,
    RP_RD   = 3'b010,
    RP_DATA = 3'b100
  } replay_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  error_stage;
    logic [15:0] error_total;
    logic [15:0] good_total;
  } res_t;

endpackage

// ===== rtl/dsfr_payload_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_payload_mem
// Payload byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module dsfr_payload_mem #(
  parameter int  DEPTH = dsfr_pkg::MAX_PAYLOAD_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dsfr_rx_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_rx_ctrl
// Receive phase machine, checksum, counters and good-frame replay sequencer.
// ---------------------------------------------------------------------------
module dsfr_rx_ctrl #(
  parameter int  MAX_PAYLOAD = dsfr_pkg::MAX_PAYLOAD_DEF,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int LW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          byte_data,
  input  logic                out_free,
  output logic                byte_take,
  output logic                res_load,
  output dsfr_pkg::res_t      res,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [7:0]          mem_rdata
);

  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_PAYLOAD);

  dsfr_pkg::phase_t  phase_r, phase_nxt;
  dsfr_pkg::replay_t rp_r, rp_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [15:0]       err_r, err_nxt;
  logic [15:0]       good_r, good_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              proceed;
  logic              err_hit;
  logic [2:0]        err_stage;
  logic [7:0]        expect_bcc;
  logic              rp_last;

  assign proceed    = byte_valid && (rp_r == dsfr_pkg::RP_IDLE) && out_free;
  assign expect_bcc = len_r[0] ? (xor_r ^ dsfr_pkg::ODD_MASK) : xor_r;
  assign rp_last    = ((LW'(idx_r) + LW'(1)) == len_r);

  always_comb begin
    phase_nxt = phase_r;
    rp_nxt    = rp_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    good_nxt  = good_r;
    idx_nxt   = idx_r;
    err_hit   = 1'b0;
    err_stage = dsfr_pkg::STAGE_IDLE;
    byte_take = 1'b0;
    res_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = len_r[AW-1:0];
    mem_wdata = byte_data;
    mem_re    = 1'b0;
    mem_raddr = idx_r;
    res.kind        = dsfr_pkg::KIND_PAYLOAD;
    res.data        = 8'd0;
    res.last        = 1'b0;
    res.error_stage = dsfr_pkg::STAGE_IDLE;

    case (rp_r)
      dsfr_pkg::RP_IDLE: begin
        if (proceed) begin
          byte_take = 1'b1;
          case (phase_r)
            dsfr_pkg::PH_IDLE: begin
              if (byte_data == dsfr_pkg::CH_DLE) begin
                phase_nxt = dsfr_pkg::PH_STX;
              end else begin
                err_hit   = 1'b1;
                err_stage = dsfr_pkg::STAGE_IDLE;
              end
            end
            dsfr_pkg::PH_STX: begin
              if (byte_data == dsfr_pkg::CH_STX) begin
                len_nxt   = '0;
                xor_nxt   = 8'd0;
                phase_nxt = dsfr_pkg::PH_PAYLOAD;
              end else begin
                err_hit   = 1'b1;
                err_stage = dsfr_pkg::STAGE_STX;
              end
            end
            dsfr_pkg::PH_PAYLOAD: begin
              if (byte_data == dsfr_pkg::CH_DLE) begin
                phase_nxt = dsfr_pkg::PH_ESCAPE;
              end else if (len_r >= LEN_FULL) begin
                err_hit   = 1'b1;
                err_stage = dsfr_pkg::STAGE_PAYLOAD;
              end else begin
                mem_we  = 1'b1;
                xor_nxt = xor_r ^ byte_data;
                len_nxt = len_r + LW'(1);
              end
            end
            dsfr_pkg::PH_ESCAPE: begin
              if (byte_data == dsfr_pkg::CH_DLE) begin
                if (len_r >= LEN_FULL) begin
                  err_hit   = 1'b1;
                  err_stage = dsfr_pkg::STAGE_ESCAPE;
                end else begin
                  mem_we    = 1'b1;
                  xor_nxt   = xor_r ^ byte_data;
                  len_nxt   = len_r + LW'(1);
                  phase_nxt = dsfr_pkg::PH_PAYLOAD;
                end
              end else if (byte_data == dsfr_pkg::CH_ETX) begin
                phase_nxt = dsfr_pkg::PH_CHECK;
              end else if (byte_data == dsfr_pkg::CH_STX) begin
                // restart collection inside the frame
                len_nxt   = '0;
                xor_nxt   = 8'd0;
                phase_nxt = dsfr_pkg::PH_PAYLOAD;
              end else begin
                err_hit   = 1'b1;
                err_stage = dsfr_pkg::STAGE_ESCAPE;
              end
            end
            dsfr_pkg::PH_CHECK: begin
              if (byte_data != expect_bcc) begin
                err_hit   = 1'b1;
                err_stage = dsfr_pkg::STAGE_CHECK;
              end else begin
                phase_nxt = dsfr_pkg::PH_IDLE;
                if (good_r != dsfr_pkg::COUNT_MAX) begin
                  good_nxt = good_r + 16'd1;
                end
                if (len_r == '0) begin
                  res_load = 1'b1;
                  res.kind = dsfr_pkg::KIND_EMPTY;
                  res.last = 1'b1;
                end else begin
                  idx_nxt = '0;
                  rp_nxt  = dsfr_pkg::RP_RD;
                end
              end
            end
            default: begin
              // drop the byte and recover
              phase_nxt = dsfr_pkg::PH_IDLE;
            end
          endcase
          if (err_hit) begin
            phase_nxt       = dsfr_pkg::PH_IDLE;
            res_load        = 1'b1;
            res.kind        = dsfr_pkg::KIND_ERROR;
            res.data        = byte_data;
            res.last        = 1'b1;
            res.error_stage = err_stage;
          end
        end
      end
      dsfr_pkg::RP_RD: begin
        mem_re = 1'b1;
        rp_nxt = dsfr_pkg::RP_DATA;
      end
      dsfr_pkg::RP_DATA: begin
        if (out_free) begin
          res_load = 1'b1;
          res.data = mem_rdata;
          res.last = rp_last;
          if (rp_last) begin
            rp_nxt = dsfr_pkg::RP_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rp_nxt  = dsfr_pkg::RP_RD;
          end
        end
      end
      default: begin
        rp_nxt = dsfr_pkg::RP_IDLE;
      end
    endcase

    err_nxt = err_r;
    if (err_hit && (err_r != dsfr_pkg::COUNT_MAX)) begin
      err_nxt = err_r + 16'd1;
    end
    res.error_total = err_nxt;
    res.good_total  = good_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dsfr_pkg::PH_IDLE;
      rp_r    <= dsfr_pkg::RP_IDLE;
      len_r   <= '0;
      xor_r   <= 8'd0;
      err_r   <= 16'd0;
      good_r  <= 16'd0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rp_r    <= rp_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      err_r   <= err_nxt;
      good_r  <= good_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/dle_stx_frame_receiver.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dle_stx_frame_receiver
// Deframer for DLE STX payload DLE ETX BCC byte-stuffed frames.
// ---------------------------------------------------------------------------
// Each received byte passes through the input holding register and then the
// phase machine, which must take it before the next byte is accepted. A good
// frame of N payload bytes is replayed from the payload memory byte by byte,
// each as a read state and then an output load that waits for a free output
// slot, since the single read port has a registered output; no new byte is
// processed during replay. An empty good frame, and every framing or checksum
// error, gives one result. Payload bytes beyond MAX_PAYLOAD abort the frame.
// ---------------------------------------------------------------------------
`include "dle_stx_frame_receiver_defines.svh"

module dle_stx_frame_receiver #(
  parameter int MAX_PAYLOAD = dsfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] data, [10:8] error_stage, [26:11] error_total, [42:27] good_total
  output logic [dsfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  output logic [1:0]                       out_tuser   // [1:0] kind
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic           hold_valid_r, hold_valid_nxt;
  logic [7:0]     hold_byte_r;
  logic           out_valid_r, out_valid_nxt;
  dsfr_pkg::res_t out_res_r;
  logic           out_free;
  logic           byte_take;
  logic           res_load;
  dsfr_pkg::res_t res;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;

  assign in_tready = !hold_valid_r;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (byte_take) begin
      hold_valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      hold_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_byte_r <= in_tdata;
    end
    if (res_load) begin
      out_res_r <= res;
    end
  end

  dsfr_rx_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (hold_valid_r),
    .byte_data  (hold_byte_r),
    .out_free   (out_free),
    .byte_take  (byte_take),
    .res_load   (res_load),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  dsfr_payload_mem #(
    .DEPTH (MAX_PAYLOAD)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {5'd0, out_res_r.good_total, out_res_r.error_total,
                       out_res_r.error_stage, out_res_r.data};

  `DSFR_ASSERT_NOW(a_take_needs_byte, byte_take, hold_valid_r)
  `DSFR_ASSERT_NOW(a_load_needs_slot, res_load, out_free)
  `DSFR_ASSERT_NOW(a_single_result_last,
    res_load && (res.kind == dsfr_pkg::KIND_ERROR || res.kind == dsfr_pkg::KIND_EMPTY),
    res.last && byte_take)
  `DSFR_ASSERT_NEXT(a_err_total_monotonic, res_load && out_valid_nxt,
    !res_load || (res.error_total >= $past(res.error_total)))

endmodule

// ===== tb/sv/dsfr_deframe_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfr_deframe_checker
// Watches both stream channels of the DLE/STX frame receiver, predicts the
// results of every accepted link byte and compares each delivered result,
// field by field, with the oldest prediction still owed.
// ---------------------------------------------------------------------------
module dsfr_deframe_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] data, [10:8] error_stage, [26:11] error_total, [42:27] good_total
  input  logic [dsfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  input  logic [1:0]                       out_tuser,  // [1:0] kind
  output int                               mismatch_total,
  output int                               results_owed
);
  import dsfr_pkg::*;

  localparam int PRINT_CAP = 100;

  phase_t      rx_state = PH_IDLE;
  logic [6:0]  frame_len = '0;
  logic [7:0]  frame_xor = '0;
  logic [7:0]  frame_buf [MAX_PAYLOAD_DEF];
  logic [15:0] err_seen = '0;
  logic [15:0] good_seen = '0;
  res_t        owed_q [$];
  int          mismatch_cnt = 0;

  initial begin
    mismatch_total = 0;
    results_owed = 0;
  end

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    if (mismatch_cnt < PRINT_CAP)
      $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic post_result(input logic [1:0] kind, input logic [7:0] data,
                             input logic last, input logic [2:0] stage);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    r.error_stage = stage;
    r.error_total = err_seen;
    r.good_total = good_seen;
    owed_q.push_back(r);
  endtask

  task automatic raise_error(input logic [7:0] b, input logic [2:0] stage);
    if (err_seen != COUNT_MAX) err_seen++;
    rx_state = PH_IDLE;
    post_result(KIND_ERROR, b, 1'b1, stage);
  endtask

  // store one payload byte; refuse it once the buffer is full
  function automatic bit keep_byte(input logic [7:0] b);
    if (frame_len >= MAX_PAYLOAD_DEF) return 1'b0;
    frame_buf[frame_len] = b;
    frame_xor ^= b;
    frame_len++;
    return 1'b1;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] bcc;
    case (rx_state)
      PH_IDLE: begin
        if (b == CH_DLE) rx_state = PH_STX;
        else raise_error(b, STAGE_IDLE);
      end
      PH_STX: begin
        if (b == CH_STX) begin
          frame_len = '0;
          frame_xor = '0;
          rx_state = PH_PAYLOAD;
        end else begin
          raise_error(b, STAGE_STX);
        end
      end
      PH_PAYLOAD: begin
        if (b == CH_DLE) rx_state = PH_ESCAPE;
        else if (!keep_byte(b)) raise_error(b, STAGE_PAYLOAD);
      end
      PH_ESCAPE: begin
        if (b == CH_DLE) begin
          if (keep_byte(b)) rx_state = PH_PAYLOAD;
          else raise_error(b, STAGE_ESCAPE);
        end else if (b == CH_ETX) begin
          rx_state = PH_CHECK;
        end else if (b == CH_STX) begin
          // restart collection inside the frame
          frame_len = '0;
          frame_xor = '0;
          rx_state = PH_PAYLOAD;
        end else begin
          raise_error(b, STAGE_ESCAPE);
        end
      end
      PH_CHECK: begin
        bcc = frame_xor ^ (frame_len[0] ? ODD_MASK : 8'h00);
        if (b != bcc) begin
          raise_error(b, STAGE_CHECK);
        end else begin
          if (good_seen != COUNT_MAX) good_seen++;
          rx_state = PH_IDLE;
          if (frame_len == 0) begin
            post_result(KIND_EMPTY, 8'h00, 1'b1, STAGE_IDLE);
          end else begin
            for (int i = 0; i < frame_len; i++)
              post_result(KIND_PAYLOAD, frame_buf[i], i == frame_len - 1, STAGE_IDLE);
          end
        end
      end
      default: rx_state = PH_IDLE;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      // match delivered results before predicting from this edge's request
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, '0);
        end else begin
          want = owed_q.pop_front();
          if (out_tuser != want.kind)
            report_mismatch("kind", out_tuser, want.kind);
          if (out_tdata[7:0] != want.data)
            report_mismatch("data", out_tdata[7:0], want.data);
          if (out_tlast != want.last)
            report_mismatch("last", out_tlast, want.last);
          if (out_tdata[10:8] != want.error_stage)
            report_mismatch("error_stage", out_tdata[10:8], want.error_stage);
          if (out_tdata[26:11] != want.error_total)
            report_mismatch("error_total", out_tdata[26:11], want.error_total);
          if (out_tdata[42:27] != want.good_total)
            report_mismatch("good_total", out_tdata[42:27], want.good_total);
          if (out_tdata[OUT_TDATA_W-1:43] != '0)
            report_mismatch("tdata padding", out_tdata[OUT_TDATA_W-1:43], '0);
        end
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
    end
    mismatch_total <= mismatch_cnt;
    results_owed <= owed_q.size();
  end

endmodule

// ===== tb/sv/dle_stx_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dle_stx_frame_receiver_tb
// Feeds the frame receiver a directed set of framing cases, a long output
// hold-off, and random well-formed and broken frame traffic; the checker
// beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module dle_stx_frame_receiver_tb;
  import dsfr_pkg::*;

  localparam int RANDOM_BYTES = 230;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 9;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [1:0]             out_tuser;

  int         mismatches;
  int         outstanding;
  bit         calm = 1'b0;
  bit         stall_req = 1'b0;
  int         bytes_sent = 0;
  logic [7:0] link_q [$];
  logic [7:0] payload_q [$];

  dle_stx_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  dsfr_deframe_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .mismatch_total (mismatches),
    .results_owed   (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // bias toward the control characters
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) return CH_DLE;
    if (r < 23) return CH_STX;
    if (r < 28) return CH_ETX;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic fill_payload(input int len);
    payload_q.delete();
    repeat (len) payload_q.push_back(pick_byte());
  endtask

  // stuff payload_q into a frame and append it to the link
  task automatic add_frame(input bit bad_bcc);
    logic [7:0] bcc;
    bcc = 8'h00;
    link_q.push_back(CH_DLE);
    link_q.push_back(CH_STX);
    foreach (payload_q[i]) begin
      if (payload_q[i] == CH_DLE) link_q.push_back(CH_DLE);
      link_q.push_back(payload_q[i]);
      bcc ^= payload_q[i];
    end
    link_q.push_back(CH_DLE);
    link_q.push_back(CH_ETX);
    if (payload_q.size() % 2 == 1) bcc ^= ODD_MASK;
    if (bad_bcc) bcc ^= 8'($urandom_range(1, 255));
    link_q.push_back(bcc);
  endtask

  task automatic add_random_traffic();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      // now and then, open a frame that the next DLE STX restarts
      if ($urandom_range(0, 9) == 0) begin
        link_q.push_back(CH_DLE);
        link_q.push_back(CH_STX);
        repeat ($urandom_range(0, 3)) link_q.push_back(8'h20 + 8'($urandom_range(0, 8'hDF)));
      end
      len = ($urandom_range(0, 99) < 3) ? $urandom_range(63, 66) : $urandom_range(0, 10);
      fill_payload(len);
      if (len > MAX_PAYLOAD_DEF && $urandom_range(0, 1) == 1) payload_q[MAX_PAYLOAD_DEF] = CH_DLE;
      add_frame($urandom_range(0, 99) < 15);
    end else if (pick < 86) begin
      repeat ($urandom_range(1, 4)) link_q.push_back(pick_byte());
    end else begin
      link_q.push_back(CH_DLE);
      link_q.push_back(CH_STX);
      repeat ($urandom_range(0, 3)) link_q.push_back(pick_byte());
      link_q.push_back(CH_DLE);
      link_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic flush_link();
    foreach (link_q[i]) send_byte(link_q[i]);
    link_q.delete();
  endtask

  // hold requests until every predicted result has been delivered
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (outstanding != 0 && guard < 100000);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int rand_start;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray bytes while idle, then DLE without STX
    link_q = '{8'h00, 8'hFF, CH_DLE, 8'h55};
    payload_q.delete();
    add_frame(1'b0);
    payload_q = '{8'hFF};
    add_frame(1'b0);
    // restart inside a frame, literal DLE, wrong check byte
    link_q.push_back(CH_DLE);
    link_q.push_back(CH_STX);
    link_q.push_back(8'h7E);
    payload_q = '{CH_DLE, 8'h00};
    add_frame(1'b1);
    // DLE followed by a byte with no meaning
    link_q.push_back(CH_DLE);
    link_q.push_back(CH_STX);
    link_q.push_back(8'hAA);
    link_q.push_back(CH_DLE);
    link_q.push_back(8'h80);
    flush_link();
    wait_drained();

    // back up a full frame behind a stalled result side
    stall_req = 1'b1;
    fill_payload(MAX_PAYLOAD_DEF);
    add_frame(1'b0);
    repeat (3) begin
      payload_q.delete();
      add_frame(1'b0);
    end
    flush_link();
    wait_drained();

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      calm = (bytes_sent - rand_start >= 120) && (bytes_sent - rand_start < 220);
      add_random_traffic();
      flush_link();
    end
    calm = 1'b0;
    wait_drained();

    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
